FILE: sv/pph_pkg.sv
`timescale 1ns / 1ps
// pph_pkg: shared constants for the perturbed-probe hash table
// result status codes and hash width; no dependencies
package pph_pkg;

  localparam int HASH_W   = 64;
  localparam int KEY_IN_W = 64;
  localparam int VAL_IN_W = 32;
  localparam int STAT_W   = 3;
  localparam int PROBE_W  = 11;
  localparam int CFG_W    = 4;
  localparam int MIN_LOG2 = 3;
  localparam int PERT_SH  = 5;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_LIMIT    = 3'd4;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

endpackage

FILE: sv/pph_ram.sv
`timescale 1ns / 1ps
// pph_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module pph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/perturbed_probe_hash_table.sv
`timescale 1ns / 1ps
// perturbed_probe_hash_table: open-addressing map with perturbed probing and rebuild
// depends on pph_pkg and pph_ram (slot table and entry store)
//
//  channel | signals                                          | direction
//  in      | in_valid_i, in_stall_o, action_i, lookup_key_i,   | into block
//          | key_hash_i, write_value_i                         |
//  out     | out_valid_o, out_stall_i, status_o, read_value_o, | out of block
//          | probes_o                                          |
//  cfg     | cfg_we_i, cfg_wdata_i                             | into block
//
//  an item is taken and checked; each occupied slot probed needs slot read, entry read and
//  compare, the empty slot that ends a probe a slot read and its wait, then a step hands
//  over the result; a refused insert skips to handover; the slot ram read port sets this
//  a resize clears all MAX_CAPACITY slots (one per cycle) then reinserts every entry
//  after reset and after a cfg write the same clearing pass runs
//  one item at a time; the next item is taken while the result waits in the output
module perturbed_probe_hash_table
  import pph_pkg::*;
#(
  parameter int MAX_CAPACITY = 1024,
  parameter int KEY_WIDTH    = 64,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                action_i,
  input  logic [KEY_IN_W-1:0] lookup_key_i,
  input  logic [HASH_W-1:0]   key_hash_i,
  input  logic [VAL_IN_W-1:0] write_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STAT_W-1:0]   status_o,
  output logic [VAL_IN_W-1:0] read_value_o,
  output logic [PROBE_W-1:0]  probes_o
);

  localparam int LW   = $clog2(MAX_CAPACITY);
  localparam int CW   = LW + 1;
  localparam int NW   = LW + 2;
  localparam int LGW  = $clog2(LW + 1);
  localparam int KW   = KEY_WIDTH;
  localparam int VSW  = (VALUE_WIDTH < VAL_IN_W) ? VALUE_WIDTH : VAL_IN_W;
  localparam int EW   = HASH_W + KW + VSW;
  localparam int SW   = LW + 1;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CLEAR     = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_RB_RD     = 4'd3;
  localparam logic [3:0] S_RB_WAIT   = 4'd4;
  localparam logic [3:0] S_SLOT_RD   = 4'd5;
  localparam logic [3:0] S_SLOT_WAIT = 4'd6;
  localparam logic [3:0] S_ENT_WAIT  = 4'd7;
  localparam logic [3:0] S_FIN       = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [LW-1:0]       clr_q, clr_d;
  logic [LGW-1:0]      log2_q, log2_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                rb_q, rb_d;
  logic [CW-1:0]       rb_n_q, rb_n_d;
  logic [CW-1:0]       rb_i_q, rb_i_d;
  logic                out_valid_q, out_valid_d;

  logic                item_act_q, item_act_d;
  logic [KW-1:0]       item_k_q, item_k_d;
  logic [HASH_W-1:0]   item_h_q, item_h_d;
  logic [VSW-1:0]      item_v_q, item_v_d;
  logic [HASH_W-1:0]   w_h_q, w_h_d;
  logic [KW-1:0]       w_k_q, w_k_d;
  logic [VSW-1:0]      w_v_q, w_v_d;
  logic [LW-1:0]       idx_q, idx_d;
  logic [HASH_W-1:0]   pert_q, pert_d;
  logic [NW-1:0]       n_q, n_d;
  logic [LW-1:0]       ent_q, ent_d;
  logic [STAT_W-1:0]   res_st_q, res_st_d;
  logic [VSW-1:0]      res_v_q, res_v_d;
  logic [NW-1:0]       res_n_q, res_n_d;
  logic [STAT_W-1:0]   out_st_q, out_st_d;
  logic [VSW-1:0]      out_v_q, out_v_d;
  logic [NW-1:0]       out_n_q, out_n_d;

  logic                slot_we;
  logic [LW-1:0]       slot_waddr, slot_raddr;
  logic [SW-1:0]       slot_wdata, slot_rdata;
  logic                ent_we;
  logic [LW-1:0]       ent_waddr, ent_raddr;
  logic [EW-1:0]       ent_wdata, ent_rdata;

  logic [CW-1:0]       cap;
  logic [LW-1:0]       mask;
  logic [CW-1:0]       thr;
  logic [LGW-1:0]      cfg_log2;
  logic [HASH_W-1:0]   rd_h;
  logic [KW-1:0]       rd_k;
  logic [VSW-1:0]      rd_v;

  logic                fin;
  logic [STAT_W-1:0]   fin_st;
  logic [VSW-1:0]      fin_v;
  logic [NW-1:0]       fin_n;
  logic                start;
  logic [HASH_W-1:0]   start_h;

  assign cap  = CW'(1) << log2_q;
  assign mask = LW'(cap - CW'(1));
  assign rd_h = ent_rdata[EW-1 -: HASH_W];
  assign rd_k = ent_rdata[KW+VSW-1 -: KW];
  assign rd_v = ent_rdata[VSW-1:0];

  // floor(2^(log2+1) / 3) is the alternating bit pattern below bit log2+1
  always_comb begin
    int m;
    m = int'(log2_q) + 1;
    for (int j = 0; j < CW; j++) begin
      thr[j] = (j < m) && ((j % 2) == (m % 2));
    end
  end

  always_comb begin
    if (cfg_wdata_i < CFG_W'(MIN_LOG2)) begin
      cfg_log2 = LGW'(MIN_LOG2);
    end else if (int'(cfg_wdata_i) > LW) begin
      cfg_log2 = LGW'(LW);
    end else begin
      cfg_log2 = LGW'(cfg_wdata_i);
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    log2_d      = log2_q;
    cnt_d       = cnt_q;
    rb_d        = rb_q;
    rb_n_d      = rb_n_q;
    rb_i_d      = rb_i_q;
    out_valid_d = out_valid_q;
    item_act_d  = item_act_q;
    item_k_d    = item_k_q;
    item_h_d    = item_h_q;
    item_v_d    = item_v_q;
    w_h_d       = w_h_q;
    w_k_d       = w_k_q;
    w_v_d       = w_v_q;
    idx_d       = idx_q;
    pert_d      = pert_q;
    n_d         = n_q;
    ent_d       = ent_q;
    res_st_d    = res_st_q;
    res_v_d     = res_v_q;
    res_n_d     = res_n_q;
    out_st_d    = out_st_q;
    out_v_d     = out_v_q;
    out_n_d     = out_n_q;
    slot_we     = 1'b0;
    slot_waddr  = idx_q;
    slot_wdata  = '0;
    slot_raddr  = idx_q;
    ent_we      = 1'b0;
    ent_waddr   = ent_q;
    ent_wdata   = {w_h_q, w_k_q, w_v_q};
    ent_raddr   = ent_q;
    fin         = 1'b0;
    fin_st      = ST_LIMIT;
    fin_v       = '0;
    fin_n       = '0;
    start       = 1'b0;
    start_h     = item_h_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_act_d = action_i;
          item_k_d   = lookup_key_i[KW-1:0];
          item_h_d   = key_hash_i;
          item_v_d   = write_value_i[VSW-1:0];
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (item_act_q == ACT_INSERT && cnt_q >= thr) begin
          if (int'(log2_q) == LW) begin
            fin    = 1'b1;
            fin_st = ST_FULL;
          end else begin
            log2_d  = log2_q + LGW'(1);
            rb_d    = 1'b1;
            rb_n_d  = cnt_q;
            rb_i_d  = '0;
            cnt_d   = '0;
            clr_d   = '0;
            state_d = S_CLEAR;
          end
        end else begin
          start = 1'b1;
        end
      end
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + LW'(1);
        if (&clr_q) begin
          state_d = rb_q ? S_RB_RD : S_IDLE;
        end
      end
      S_RB_RD: begin
        if (rb_i_q == rb_n_q) begin
          rb_d  = 1'b0;
          start = 1'b1;
        end else begin
          ent_raddr = rb_i_q[LW-1:0];
          rb_i_d    = rb_i_q + CW'(1);
          state_d   = S_RB_WAIT;
        end
      end
      S_RB_WAIT: begin
        start   = 1'b1;
        start_h = rd_h;
      end
      S_SLOT_RD: begin
        state_d = S_SLOT_WAIT;
      end
      S_SLOT_WAIT: begin
        n_d = n_q + NW'(1);
        if (!slot_rdata[SW-1]) begin
          fin   = 1'b1;
          fin_n = n_q + NW'(1);
          if (!rb_q && item_act_q == ACT_LOOKUP) begin
            fin_st = ST_NOTFOUND;
          end else if (cnt_q[CW-1]) begin
            fin_st = ST_LIMIT;
          end else begin
            fin_st     = ST_INSERTED;
            ent_we     = 1'b1;
            ent_waddr  = cnt_q[LW-1:0];
            slot_we    = 1'b1;
            slot_waddr = idx_q;
            slot_wdata = {1'b1, cnt_q[LW-1:0]};
            cnt_d      = cnt_q + CW'(1);
          end
        end else begin
          ent_raddr = slot_rdata[LW-1:0];
          ent_d     = slot_rdata[LW-1:0];
          state_d   = S_ENT_WAIT;
        end
      end
      S_ENT_WAIT: begin
        if (rd_h == w_h_q && rd_k == w_k_q) begin
          fin   = 1'b1;
          fin_n = n_q;
          if (!rb_q && item_act_q == ACT_LOOKUP) begin
            fin_st = ST_FOUND;
            fin_v  = rd_v;
          end else begin
            fin_st = ST_UPDATED;
            ent_we = 1'b1;
          end
        end else if (n_q > {1'b0, cap}) begin
          fin    = 1'b1;
          fin_n  = n_q;
          fin_st = ST_LIMIT;
        end else begin
          idx_d   = (LW'({idx_q, 2'b00}) + idx_q + LW'(1) + pert_q[LW-1:0]) & mask;
          pert_d  = pert_q >> PERT_SH;
          state_d = S_SLOT_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_v_d     = res_v_q;
          out_n_d     = res_n_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // probe setup, from the item or from a stored entry during rebuild
    if (start) begin
      if (state_q == S_RB_WAIT) begin
        w_h_d = rd_h;
        w_k_d = rd_k;
        w_v_d = rd_v;
      end else begin
        w_h_d = item_h_q;
        w_k_d = item_k_q;
        w_v_d = item_v_q;
      end
      idx_d   = start_h[LW-1:0] & mask;
      pert_d  = start_h;
      n_d     = '0;
      state_d = S_SLOT_RD;
    end

    if (fin) begin
      if (rb_q) begin
        state_d = S_RB_RD;
      end else begin
        res_st_d = fin_st;
        res_v_d  = fin_v;
        res_n_d  = fin_n;
        state_d  = S_FIN;
      end
    end

    if (cfg_we_i) begin
      log2_d  = cfg_log2;
      cnt_d   = '0;
      rb_d    = 1'b0;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      log2_q      <= LGW'(MIN_LOG2);
      cnt_q       <= '0;
      rb_q        <= 1'b0;
      rb_n_q      <= '0;
      rb_i_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      log2_q      <= log2_d;
      cnt_q       <= cnt_d;
      rb_q        <= rb_d;
      rb_n_q      <= rb_n_d;
      rb_i_q      <= rb_i_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_act_q <= item_act_d;
    item_k_q   <= item_k_d;
    item_h_q   <= item_h_d;
    item_v_q   <= item_v_d;
    w_h_q      <= w_h_d;
    w_k_q      <= w_k_d;
    w_v_q      <= w_v_d;
    idx_q      <= idx_d;
    pert_q     <= pert_d;
    n_q        <= n_d;
    ent_q      <= ent_d;
    res_st_q   <= res_st_d;
    res_v_q    <= res_v_d;
    res_n_q    <= res_n_d;
    out_st_q   <= out_st_d;
    out_v_q    <= out_v_d;
    out_n_q    <= out_n_d;
  end

  pph_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_CAPACITY)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  pph_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign read_value_o = VAL_IN_W'(out_v_q);
  assign probes_o     = PROBE_W'(out_n_q);

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_CAPACITY))
    else $error("entry count above capacity");

  a_cfg_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> state_q == S_CLEAR && cnt_q == '0 && !rb_q)
    else $error("config write did not empty the table");

  a_log2_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    log2_q >= LGW'(MIN_LOG2) && int'(log2_q) <= LW)
    else $error("capacity out of range");

  a_clear_no_entry_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !ent_we)
    else $error("entry write during slot clear");

  a_status_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FULL)
    else $error("bad status code");

endmodule

FILE: tb/sv/tb_perturbed_probe_hash_table.sv
`timescale 1ns / 1ps
// tb_perturbed_probe_hash_table: self-checking bench for the perturbed-probe hash table
// needs pph_pkg and perturbed_probe_hash_table; a built-in map model predicts every beat
module tb_perturbed_probe_hash_table;
  import pph_pkg::*;

  localparam int MAXC = 1024;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic                act;
    logic [KEY_IN_W-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic [VAL_IN_W-1:0] val;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [VAL_IN_W-1:0] rval;
    logic [PROBE_W-1:0]  probes;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic action_i = 1'b0;
  logic [KEY_IN_W-1:0] lookup_key_i = '0;
  logic [HASH_W-1:0] key_hash_i = '0;
  logic [VAL_IN_W-1:0] write_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STAT_W-1:0] status_o;
  logic [VAL_IN_W-1:0] read_value_o;
  logic [PROBE_W-1:0] probes_o;

  always #5 clk_i = ~clk_i;

  perturbed_probe_hash_table dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .action_i, .lookup_key_i, .key_hash_i, .write_value_i,
    .out_valid_o, .out_stall_i, .status_o, .read_value_o, .probes_o
  );

  // map model state
  bit          slot_used [MAXC];
  int          slot_entry[MAXC];
  logic [63:0] ent_hash  [MAXC];
  logic [63:0] ent_key   [MAXC];
  logic [31:0] ent_val   [MAXC];
  int          cap_log2;
  int          n_entries;

  req_t pending_items[$];
  rsp_t expected_rsps[$];
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  bit   hold_go = 1'b0;
  int   hold_cnt = 0;
  int   n_errors = 0;
  int   n_sent = 0;
  int   status_seen[6];
  int   quiet_cycles = 0;

  function automatic int clamp_cap(int l);
    int top;
    top = 3;
    while ((1 << (top + 1)) <= MAXC) top++;
    if (l < MIN_LOG2) return MIN_LOG2;
    if (l > top) return top;
    return l;
  endfunction

  function automatic void clear_map(int l);
    for (int i = 0; i < MAXC; i++) begin
      slot_used[i] = 1'b0;
      slot_entry[i] = 0;
    end
    n_entries = 0;
    cap_log2 = clamp_cap(l);
  endfunction

  function automatic bit find_slot(logic [63:0] h, logic [63:0] k, output int slot,
                                   output int n);
    logic [63:0] cap, mask, idx, pert;
    cap = 64'd1 << cap_log2;
    mask = cap - 1;
    idx = h & mask;
    pert = h;
    n = 0;
    while (1'b1) begin
      n++;
      if (!slot_used[idx]) begin
        slot = int'(idx);
        return 1'b0;
      end
      if (ent_hash[slot_entry[idx]] == h && ent_key[slot_entry[idx]] == k) begin
        slot = int'(idx);
        return 1'b1;
      end
      idx = (64'd5 * idx + 64'd1 + pert) & mask;
      pert = pert >> PERT_SH;
      if (n > cap) begin
        slot = MAXC;
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [STAT_W-1:0] store_entry(logic [63:0] h, logic [63:0] k,
                                                    logic [31:0] v, output int n);
    int slot;
    if (find_slot(h, k, slot, n)) begin
      ent_val[slot_entry[slot]] = v;
      return ST_UPDATED;
    end
    if (slot >= MAXC || n_entries >= MAXC) return ST_LIMIT;
    ent_hash[n_entries] = h;
    ent_key[n_entries] = k;
    ent_val[n_entries] = v;
    slot_entry[slot] = n_entries;
    slot_used[slot] = 1'b1;
    n_entries++;
    return ST_INSERTED;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t o;
    int n, slot, old, cap;
    o = '0;
    n = 0;
    if (r.act == ACT_INSERT) begin
      cap = 1 << cap_log2;
      if (n_entries >= (cap * 2) / 3) begin
        if (cap * 2 > MAXC) begin
          o.status = ST_FULL;
          return o;
        end
        cap_log2++;
        old = n_entries;
        for (int i = 0; i < MAXC; i++) slot_used[i] = 1'b0;
        n_entries = 0;
        for (int i = 0; i < old; i++) void'(store_entry(ent_hash[i], ent_key[i], ent_val[i], n));
        n = 0;
      end
      o.status = store_entry(r.hash, r.key, r.val, n);
    end else if (find_slot(r.hash, r.key, slot, n)) begin
      o.status = ST_FOUND;
      o.rval = ent_val[slot_entry[slot]];
    end else begin
      o.status = (slot >= MAXC) ? ST_LIMIT : ST_NOTFOUND;
    end
    o.probes = n[PROBE_W-1:0];
    return o;
  endfunction

  // driver
  always @(posedge clk_i) begin
    req_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_rsps.push_back(predict_rsp({action_i, lookup_key_i, key_hash_i,
                                             write_value_i}));
        n_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i <= 1'b1;
          action_i <= nxt.act;
          lookup_key_i <= nxt.key;
          key_hash_i <= nxt.hash;
          write_value_i <= nxt.val;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $error("result beat with nothing expected: status %0d", status_o);
          n_errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (status_o < 6) status_seen[status_o]++;
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_errors++;
          end
          if (read_value_o !== want.rval) begin
            $error("read_value: expected %h, got %h", want.rval, read_value_o);
            n_errors++;
          end
          if (probes_o !== want.probes) begin
            $error("probes: expected %0d, got %0d", want.probes, probes_o);
            n_errors++;
          end
        end
      end
      if (hold_go) begin
        hold_cnt <= 400;
        out_stall_i <= 1'b1;
      end else if (hold_cnt != 0) begin
        hold_cnt <= hold_cnt - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("tb_perturbed_probe_hash_table: errors");
      $finish;
    end
  end

  logic [63:0] key_pool[$];
  logic [63:0] hash_pool[$];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void add_item(logic a, logic [63:0] k, logic [63:0] h, logic [31:0] v);
    req_t r;
    r.act = a;
    r.key = k;
    r.hash = h;
    r.val = v;
    pending_items.push_back(r);
  endfunction

  // new keys: some share a full hash, some only the low bits, the rest are random
  function automatic void add_new_key(logic a);
    logic [63:0] k, h;
    int pick;
    k = rand64();
    h = rand64();
    pick = $urandom_range(9);
    if (hash_pool.size() != 0 && pick < 2) begin
      h = hash_pool[$urandom_range(hash_pool.size() - 1)];
    end else if (hash_pool.size() != 0 && pick < 4) begin
      h[9:0] = hash_pool[$urandom_range(hash_pool.size() - 1)][9:0];
    end
    if (a == ACT_INSERT) begin
      key_pool.push_back(k);
      hash_pool.push_back(h);
    end
    add_item(a, k, h, $urandom());
  endfunction

  function automatic void add_random(int n, int new_pct);
    int j;
    logic a;
    for (int i = 0; i < n; i++) begin
      a = 1'($urandom_range(1));
      if (key_pool.size() == 0 || $urandom_range(99) < new_pct) begin
        add_new_key(a);
      end else begin
        j = $urandom_range(key_pool.size() - 1);
        add_item(a, key_pool[j], hash_pool[j], $urandom());
      end
    end
  endfunction

  task automatic drain();
    while (pending_items.size() != 0 || in_valid_i || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_capacity(int l);
    drain();
    cfg_wdata_i <= l[CFG_W-1:0];
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    clear_map(l & 15);
    key_pool.delete();
    hash_pool.delete();
  endtask

  task automatic set_pace(int mode);
    case (mode)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 76; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 76; end
      default: begin send_idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  initial begin
    clear_map(3);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, update, miss, same-hash chain forcing a resize
    add_item(ACT_INSERT, '0, '0, '0);
    add_item(ACT_INSERT, '1, '1, '1);
    add_item(ACT_LOOKUP, '0, '0, '0);
    add_item(ACT_LOOKUP, '1, '1, '1);
    add_item(ACT_INSERT, '0, '0, 32'hA5A5_5A5A);
    add_item(ACT_LOOKUP, '0, '0, '1);
    add_item(ACT_LOOKUP, 64'h1, '0, '0);
    add_item(ACT_LOOKUP, '1, '0, '0);
    for (int i = 1; i <= 8; i++) add_item(ACT_INSERT, 64'(i), 64'h7, 32'(i * 3));
    for (int i = 1; i <= 8; i++) add_item(ACT_LOOKUP, 64'(i), 64'h7, '0);
    drain();

    // out-of-range register values clamp to the ends
    set_capacity(0);
    set_pace(3);
    add_random(60, 40);
    set_capacity(15);
    set_pace(1);
    add_random(60, 40);

    // fill to maximum capacity until inserts are refused
    set_capacity(9);
    set_pace(0);
    for (int i = 0; i < 700; i++) begin
      add_new_key(ACT_INSERT);
      if (i % 10 == 0) add_random(1, 0);
    end
    add_random(20, 30);
    drain();

    // long receiver hold-off while the sender keeps offering
    set_capacity(3);
    set_pace(0);
    add_random(30, 50);
    @(posedge clk_i);
    hold_go <= 1'b1;
    @(posedge clk_i);
    hold_go <= 1'b0;

    for (int ph = 0; ph < 8; ph++) begin
      set_capacity((ph % 4 == 0) ? 10 : 3 + (ph % 5));
      set_pace(ph % 4);
      add_random(70, 45);
    end
    set_capacity(3);
    set_pace(2);
    add_random(40, 50);

    drain();
    repeat (50) @(posedge clk_i);
    $display("ran %0d beats: inserted %0d, updated %0d, found %0d, missed %0d, full %0d",
             n_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[5]);
    $display("capacities 8 to 1024 across resizes, clamped register values and stalls");
    if (n_errors == 0) begin
      $display("tb_perturbed_probe_hash_table: clean");
    end else begin
      $display("tb_perturbed_probe_hash_table: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/pph_pkg.sv
sv/pph_ram.sv
sv/perturbed_probe_hash_table.sv
tb/sv/tb_perturbed_probe_hash_table.sv
